### design/btk_pkg.sv
package btk_pkg;

  localparam int unsigned BETA_DEF  = 4;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TIE_BAND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UTIL_TOL = CFG_IDX_W'(1);

  localparam logic [15:0] TIE_BAND_RST = 16'd33;
  localparam logic [15:0] UTIL_TOL_RST = 16'd3;

  localparam logic OP_OFFER  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic [15:0] tie_band;
    logic [15:0] util_tol;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] id;
    logic [15:0] score;
    logic [15:0] util;
    logic [9:0]  pieces;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  slot;
    logic        entry_valid;
    logic [15:0] id;
    logic [15:0] score;
    logic [9:0]  pieces;
    logic        last;
  } res_t;

  // handshake between engine and a queue
  typedef struct packed {
    logic avail;
    logic full;
  } qstat_t;

endpackage

### design/btk_fifo.sv
module btk_fifo import btk_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QDEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output qstat_t           stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.avail = (cnt_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.avail;
  assign rdata_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### design/btk_engine.sv
module btk_engine import btk_pkg::*; #(
  parameter int unsigned BETA = BETA_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  item_t  item_i,
  input  qstat_t in_stat_i,
  output logic   item_pop_o,
  input  qstat_t res_stat_i,
  output res_t   res_o,
  output logic   res_push_o
);

  localparam int unsigned CW = $clog2(BETA + 1);
  localparam int unsigned IW = (BETA > 1) ? $clog2(BETA) : 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INSERT = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [15:0] score_q  [BETA];
  logic [15:0] util_q   [BETA];
  logic [15:0] id_q     [BETA];
  logic [9:0]  pieces_q [BETA];
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] k_q, k_d;

  // candidate held between decision and insert
  item_t         cand_q, cand_d;
  logic          ins_q, ins_d;
  logic [CW-1:0] pos_q, pos_d;

  logic [16:0]   s17, sb, ub, band17;
  logic [IW-1:0] widx, pidx;
  logic [15:0]   ws, wu;
  logic          acc;
  logic [CW-1:0] pos;
  logic [BETA-1:0] pass;

  assign band17 = {1'b0, cfg_i.tie_band};
  assign s17    = {1'b0, item_i.score};
  assign sb     = s17 + band17;
  assign ub     = {1'b0, item_i.util} + {1'b0, cfg_i.util_tol};
  assign widx   = IW'(cnt_q - 1'b1);
  assign ws     = score_q[widx];
  assign wu     = util_q[widx];
  assign pidx   = IW'(pos_q);

  // acceptance test: accept while the list has room, else test against the worst kept entry
  always_comb begin
    acc = 1'b0;
    if (cnt_q == '0 || cnt_q < CW'(BETA)) begin
      acc = 1'b1;
    end else if (s17 >= ({1'b0, ws} + band17)) begin
      acc = 1'b1;
    end else if (sb >= {1'b0, ws} && ub > {1'b0, wu}) begin
      acc = 1'b1;
    end
  end

  // entries the candidate sorts behind; first miss is the slot
  always_comb begin
    for (int i = 0; i < BETA; i++) begin
      pass[i] = (sb <= {1'b0, score_q[i]}) ||
                ((s17 <= ({1'b0, score_q[i]} + band17)) && (item_i.util < util_q[i]));
    end
    pos = cnt_q;
    for (int i = BETA - 1; i >= 0; i--) begin
      if (CW'(i) < cnt_q && !pass[i]) begin
        pos = CW'(i);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    cand_d     = cand_q;
    ins_d      = ins_q;
    pos_d      = pos_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_stat_i.avail) begin
          item_pop_o = 1'b1;
          if (item_i.operation == OP_FINISH) begin
            k_d     = '0;
            state_d = ST_EMIT;
          end else begin
            cand_d  = item_i;
            // sorting past the end of a full list is a reject
            ins_d   = acc && (pos < CW'(BETA));
            pos_d   = (acc && (pos < CW'(BETA))) ? pos : '0;
            state_d = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        res_o.accepted = ins_q;
        res_o.slot     = 4'(pos_q);
        res_o.last     = 1'b1;
        if (!res_stat_i.full) begin
          res_push_o = 1'b1;
          if (ins_q && cnt_q < CW'(BETA)) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        res_o.last = 1'b1;
        if (cnt_q != '0) begin
          res_o.slot        = 4'(k_q);
          res_o.entry_valid = 1'b1;
          res_o.id          = id_q[k_q];
          res_o.score       = score_q[k_q];
          res_o.pieces      = pieces_q[k_q];
          res_o.last        = (CW'(k_q) + 1'b1 == cnt_q);
        end
        if (!res_stat_i.full) begin
          res_push_o = 1'b1;
          if (res_o.last) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    cand_q <= cand_d;
    ins_q  <= ins_d;
    pos_q  <= pos_d;
  end

  // shift the tail down one place, then drop the candidate in
  always_ff @(posedge clk_i) begin
    if (state_q == ST_INSERT && !res_stat_i.full && ins_q) begin
      for (int i = 1; i < BETA; i++) begin
        if (CW'(i) > pos_q && (cnt_q == CW'(BETA) || CW'(i) <= cnt_q)) begin
          score_q[i]  <= score_q[i-1];
          util_q[i]   <= util_q[i-1];
          id_q[i]     <= id_q[i-1];
          pieces_q[i] <= pieces_q[i-1];
        end
      end
      score_q[pidx]  <= cand_q.score;
      util_q[pidx]   <= cand_q.util;
      id_q[pidx]     <= cand_q.id;
      pieces_q[pidx] <= cand_q.pieces;
    end
  end

endmodule

### design/beam_top_k_keeper_top.sv
// Path: an offer's result reaches the outputs via the input queue, then decide, then insert.
// Offers: the list engine takes a new offer only once the decide/insert sequence of the last is done;
//   a finish streams the kept list, one emitted entry per cycle while the result queue has room.
// Front and back queues hold 2 items each, so push and pop stall independently.
// Reset (rst_ni low, async): queues and kept list empty, tie_band=33, util_tolerance=3.
module beam_top_k_keeper_top import btk_pkg::*; #(
  parameter int unsigned BETA = BETA_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  // candidate / finish input queue
  input  logic                 push,
  output logic                 full,
  input  logic                 operation_i,
  input  logic [15:0]          cand_id_i,
  input  logic [15:0]          cand_score_i,
  input  logic [15:0]          cand_util_i,
  input  logic [9:0]           cand_pieces_i,
  // result queue
  output logic                 empty,
  input  logic                 pop,
  output logic                 accepted_o,
  output logic [3:0]           slot_o,
  output logic                 entry_valid_o,
  output logic [15:0]          kept_id_o,
  output logic [15:0]          kept_score_o,
  output logic [9:0]           kept_pieces_o,
  output logic                 last_o
);

  cfg_t   cfg_q, cfg_d;
  item_t  in_item, eng_item;
  res_t   eng_res, out_res;
  qstat_t in_stat, res_stat;
  logic   eng_pop, eng_push;

  // Config registers: always ready; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TIE_BAND: cfg_d.tie_band = cfg_data_i;
        REG_UTIL_TOL: cfg_d.util_tol = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tie_band <= TIE_BAND_RST;
      cfg_q.util_tol <= UTIL_TOL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: input queue takes a transfer whenever it has room.
  assign in_item.operation = operation_i;
  assign in_item.id        = cand_id_i;
  assign in_item.score     = cand_score_i;
  assign in_item.util      = cand_util_i;
  assign in_item.pieces    = cand_pieces_i;

  btk_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(QDEPTH)
  ) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(in_item),
    .pop_i  (eng_pop),
    .rdata_o(eng_item),
    .stat_o (in_stat)
  );

  assign full = in_stat.full;

  // Back: list engine decides, inserts, or streams the kept list out.
  btk_engine #(
    .BETA(BETA)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .item_i    (eng_item),
    .in_stat_i (in_stat),
    .item_pop_o(eng_pop),
    .res_stat_i(res_stat),
    .res_o     (eng_res),
    .res_push_o(eng_push)
  );

  // Result queue decouples the engine from the consumer.
  btk_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QDEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (eng_push),
    .wdata_i(eng_res),
    .pop_i  (pop),
    .rdata_o(out_res),
    .stat_o (res_stat)
  );

  assign empty         = !res_stat.avail;
  assign accepted_o    = out_res.accepted;
  assign slot_o        = out_res.slot;
  assign entry_valid_o = out_res.entry_valid;
  assign kept_id_o     = out_res.id;
  assign kept_score_o  = out_res.score;
  assign kept_pieces_o = out_res.pieces;
  assign last_o        = out_res.last;

endmodule
